[sv/keyed_record_table_defines.svh]
// Assertion macros for the keyed record table.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define KRT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("keyed_record_table: check failed");
`define KRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed_record_table: check failed");
`else
`define KRT_ASSERT(label, prop)
`define KRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[sv/krt_pkg.sv]
`default_nettype none

package krt_pkg;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_QUERY  = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_FIRST  = 3'd3,
    KIND_NEXT   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] plate;
    logic [63:0] brand_high;
    logic [63:0] brand_mid;
    logic [31:0] brand_low;
  } entry_t;

  typedef struct packed {
    logic take_next;  // copy the neighbor's entry (ring rotate or compaction)
    logic load;       // write a new entry from the input item
  } cell_ctrl_t;

  localparam int unsigned CapW = 6;

endpackage

`default_nettype wire

[sv/krt_cell.sv]
`default_nettype none

module krt_cell
  import krt_pkg::*;
(
  input  wire             clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire entry_t     next_i,
  input  wire entry_t     ins_i,
  output entry_t          entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= ins_i;
    end else if (ctrl_i.take_next) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[sv/keyed_record_table.sv]
// Insert and unknown kinds go from idle straight to the done state; query, get first and
//   get next pass through the scan state first, and a remove that hits also through shift.
// A new item is taken only in idle, once the last result has left the done state; a scan
//   makes one full rotation of the cell ring past the compare at cell 0.
// Reset: entry count 0, walk cursor minus one, capacity 32; stored entries are not cleared.
`default_nettype none
`include "keyed_record_table_defines.svh"

module keyed_record_table
  import krt_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,

  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [5:0]  cfg_data_i,

  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  kind_i,
  input  wire  [31:0] plate_i,
  input  wire  [63:0] brand_high_i,
  input  wire  [63:0] brand_mid_i,
  input  wire  [31:0] brand_low_i,
  input  wire  [15:0] record_handle_i,

  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        ok_o,
  output logic [15:0] found_handle_o,
  output logic [31:0] found_plate_o,
  output logic [63:0] found_brand_high_o,
  output logic [63:0] found_brand_mid_o,
  output logic [31:0] found_brand_low_o,
  output logic [5:0]  stored_count_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > CapW) ? CW : CapW;

  state_e         state_q;
  kind_e          kind_q;
  logic [31:0]    plate_q;
  logic [63:0]    bh_q;
  logic [63:0]    bm_q;
  logic [31:0]    bl_q;
  logic [IW-1:0]  scan_q;
  logic [IW-1:0]  hit_idx_q;
  logic           res_ok_q;
  entry_t         res_q;
  logic [CW-1:0]  tgt_q;
  logic           tgt_ok_q;
  logic [CW-1:0]  count_q;
  logic [CW-1:0]  cur_q;
  logic           cur_neg_q;
  logic [5:0]     cap_q;

  logic           out_valid_q;
  logic           out_ok_q;
  entry_t         out_ent_q;
  logic [5:0]     out_cnt_q;

  entry_t         cell_ent [DEPTH];
  entry_t         head;
  entry_t         ins_ent;
  kind_e          kind_in;
  logic           in_fire;
  logic           fits;
  logic [CW-1:0]  cur_adv;
  logic           key_match;
  logic           in_range;
  logic           hit_now;
  logic           scan_last;
  logic           out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign kind_in     = kind_e'(kind_i);

  assign ins_ent = '{handle: record_handle_i, plate: plate_i, brand_high: brand_high_i,
                     brand_mid: brand_mid_i, brand_low: brand_low_i};

  assign fits = (MW'(count_q) < MW'(cap_q)) && (count_q < CW'(DEPTH));

  // cursor moves from minus one to 0, then saturates at DEPTH
  assign cur_adv = cur_neg_q ? '0 :
                   ((cur_q < CW'(DEPTH)) ? CW'(cur_q + 1'b1) : cur_q);

  // ring of cells: each cell takes the entry of the next cell up, the last cell that of cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned Nxt = (i + 1) % DEPTH;
    cell_ctrl_t ctrl;

    assign ctrl.take_next = (state_q == ST_SCAN) ||
                            ((state_q == ST_SHIFT) && (IW'(i) >= hit_idx_q));
    assign ctrl.load      = in_fire && (kind_in == KIND_INSERT) && fits &&
                            (count_q == CW'(i));

    krt_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .next_i  (cell_ent[Nxt]),
      .ins_i   (ins_ent),
      .entry_o (cell_ent[i])
    );
  end

  assign head      = cell_ent[0];
  assign key_match = (head.plate == plate_q) && (head.brand_high == bh_q) &&
                     (head.brand_mid == bm_q) && (head.brand_low == bl_q);
  assign in_range  = (CW'(scan_q) < count_q);
  assign scan_last = (scan_q == IW'(DEPTH - 1));

  always_comb begin
    hit_now = 1'b0;
    case (kind_q) inside
      KIND_QUERY, KIND_REMOVE: hit_now = !res_ok_q && in_range && key_match;
      KIND_FIRST, KIND_NEXT:   hit_now = tgt_ok_q && (CW'(scan_q) == tgt_q);
      default:                 hit_now = 1'b0;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_INSERT;
      scan_q      <= '0;
      hit_idx_q   <= '0;
      res_ok_q    <= 1'b0;
      tgt_q       <= '0;
      tgt_ok_q    <= 1'b0;
      count_q     <= '0;
      cur_q       <= '0;
      cur_neg_q   <= 1'b1;
      cap_q       <= 6'd32;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            kind_q   <= kind_in;
            scan_q   <= '0;
            res_ok_q <= (kind_in == KIND_INSERT) && fits;
            tgt_ok_q <= (count_q != '0) &&
                        ((kind_in == KIND_FIRST) ||
                         ((kind_in == KIND_NEXT) && (cur_adv < count_q)));
            unique case (kind_in) inside
              KIND_INSERT: begin
                if (fits) begin
                  count_q <= CW'(count_q + 1'b1);
                end
                state_q <= ST_DONE;
              end
              KIND_QUERY, KIND_REMOVE: begin
                state_q <= ST_SCAN;
              end
              KIND_FIRST: begin
                if (count_q != '0) begin
                  cur_q     <= '0;
                  cur_neg_q <= 1'b0;
                  tgt_q     <= '0;
                end
                state_q <= ST_SCAN;
              end
              KIND_NEXT: begin
                if (count_q != '0) begin
                  cur_q     <= cur_adv;
                  cur_neg_q <= 1'b0;
                  tgt_q     <= cur_adv;
                end
                state_q <= ST_SCAN;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (hit_now) begin
            res_ok_q  <= 1'b1;
            hit_idx_q <= scan_q;
          end
          if (scan_last) begin
            state_q <= ((kind_q == KIND_REMOVE) && (res_ok_q || hit_now)) ? ST_SHIFT : ST_DONE;
          end else begin
            scan_q <= IW'(scan_q + 1'b1);
          end
        end
        ST_SHIFT: begin
          count_q <= CW'(count_q - 1'b1);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      plate_q <= plate_i;
      bh_q    <= brand_high_i;
      bm_q    <= brand_mid_i;
      bl_q    <= brand_low_i;
      res_q   <= '0;
    end else if ((state_q == ST_SCAN) && hit_now) begin
      res_q <= head;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_ok_q  <= res_ok_q;
      out_ent_q <= res_q;
      out_cnt_q <= 6'(count_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign ok_o               = out_ok_q;
  assign found_handle_o     = out_ent_q.handle;
  assign found_plate_o      = out_ent_q.plate;
  assign found_brand_high_o = out_ent_q.brand_high;
  assign found_brand_mid_o  = out_ent_q.brand_mid;
  assign found_brand_low_o  = out_ent_q.brand_low;
  assign stored_count_o     = out_cnt_q;

  `KRT_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
  `KRT_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_q != ST_IDLE)
  `KRT_ASSERT_NEXT(a_remove_drops_one, state_q == ST_SHIFT, count_q == CW'($past(count_q) - 1'b1))
  `KRT_ASSERT(a_hit_in_range, (state_q == ST_SHIFT) |-> (CW'(hit_idx_q) < count_q))

endmodule

`default_nettype wire

[tb/keyed_record_table_checker.sv]
`timescale 1ns / 100ps

module keyed_record_table_checker
  import krt_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [5:0]  cfg_data_i,

  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [31:0] plate_i,
  input  logic [63:0] brand_high_i,
  input  logic [63:0] brand_mid_i,
  input  logic [31:0] brand_low_i,
  input  logic [15:0] record_handle_i,

  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        ok_i,
  input  logic [15:0] found_handle_i,
  input  logic [31:0] found_plate_i,
  input  logic [63:0] found_brand_high_i,
  input  logic [63:0] found_brand_mid_i,
  input  logic [31:0] found_brand_low_i,
  input  logic [5:0]  stored_count_i,

  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic       ok;
    entry_t     rec;
    logic [5:0] count;
  } table_reply_t;

  // shadow copy of the table
  entry_t      rec_mem [DEPTH];
  int unsigned rec_count;
  int          walk_pos;
  logic [5:0]  cap_reg;

  table_reply_t table_replies[$];
  int           mismatches = 0;

  function automatic table_reply_t apply_table_op(logic [2:0] kind, entry_t key);
    table_reply_t r;
    int unsigned  limit;
    int unsigned  hit_idx;
    bit           hit;
    r.ok    = 1'b0;
    r.rec   = '0;
    limit   = (cap_reg < DEPTH) ? cap_reg : DEPTH;
    hit     = 1'b0;
    hit_idx = 0;
    // first entry whose whole key matches; the handle takes no part
    for (int unsigned i = 0; i < rec_count && !hit; i++) begin
      if (rec_mem[i].plate == key.plate && rec_mem[i].brand_high == key.brand_high &&
          rec_mem[i].brand_mid == key.brand_mid && rec_mem[i].brand_low == key.brand_low) begin
        hit     = 1'b1;
        hit_idx = i;
      end
    end
    case (kind)
      KIND_INSERT: begin
        if (rec_count < limit) begin
          rec_mem[rec_count] = key;
          rec_count++;
          r.ok = 1'b1;
        end
      end
      KIND_QUERY: begin
        if (hit) begin
          r.ok  = 1'b1;
          r.rec = rec_mem[hit_idx];
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          r.ok  = 1'b1;
          r.rec = rec_mem[hit_idx];
          for (int unsigned j = hit_idx; j + 1 < rec_count; j++) rec_mem[j] = rec_mem[j + 1];
          rec_count--;
        end
      end
      KIND_FIRST: begin
        if (rec_count > 0) begin
          walk_pos = 0;
          r.ok     = 1'b1;
          r.rec    = rec_mem[0];
        end
      end
      KIND_NEXT: begin
        if (rec_count > 0) begin
          if (walk_pos < int'(DEPTH)) walk_pos++;
          if (walk_pos >= 0 && walk_pos < int'(rec_count)) begin
            r.ok  = 1'b1;
            r.rec = rec_mem[walk_pos];
          end
        end
      end
      default: begin
      end
    endcase
    r.count = rec_count[5:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("keyed_record_table: %s mismatch, expected %h, actual %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t       key;
    table_reply_t want;
    if (!rst_ni) begin
      rec_count = 0;
      walk_pos  = -1;
      cap_reg   = 6'd32;
      table_replies.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_valid_i && cfg_ready_i) cap_reg = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        key.handle     = record_handle_i;
        key.plate      = plate_i;
        key.brand_high = brand_high_i;
        key.brand_mid  = brand_mid_i;
        key.brand_low  = brand_low_i;
        table_replies.push_back(apply_table_op(kind_i, key));
      end
      if (out_valid_i && !out_stall_i) begin
        if (table_replies.size() == 0) begin
          $error("keyed_record_table: result item with no pending expectation");
          mismatches++;
        end else begin
          want = table_replies.pop_front();
          check_field("ok", want.ok, ok_i);
          check_field("found_handle", want.rec.handle, found_handle_i);
          check_field("found_plate", want.rec.plate, found_plate_i);
          check_field("found_brand_high", want.rec.brand_high, found_brand_high_i);
          check_field("found_brand_mid", want.rec.brand_mid, found_brand_mid_i);
          check_field("found_brand_low", want.rec.brand_low, found_brand_low_i);
          check_field("stored_count", want.count, stored_count_i);
        end
      end
      pending_o    <= table_replies.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[tb/keyed_record_table_tb.sv]
`timescale 1ns / 100ps

module keyed_record_table_tb;
  import krt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          HOLD_CYCLES = 600;
  localparam int          SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam logic [2:0]  KIND_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0]  KIND_UNKNOWN_LAST  = 3'd7;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic [5:0]  cfg_data = '0;
  wire         cfg_ready;

  logic        in_valid = 1'b0;
  logic [2:0]  op_kind = '0;
  logic [31:0] op_plate = '0;
  logic [63:0] op_brand_high = '0;
  logic [63:0] op_brand_mid = '0;
  logic [31:0] op_brand_low = '0;
  logic [15:0] op_handle = '0;
  wire         in_stall;

  wire         out_valid;
  logic        out_stall = 1'b0;
  wire         ok;
  wire  [15:0] found_handle;
  wire  [31:0] found_plate;
  wire  [63:0] found_brand_high;
  wire  [63:0] found_brand_mid;
  wire  [31:0] found_brand_low;
  wire  [5:0]  stored_count;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  entry_t key_pool [8];

  always #2 clk = ~clk;

  keyed_record_table #(
    .DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .kind_i            (op_kind),
    .plate_i           (op_plate),
    .brand_high_i      (op_brand_high),
    .brand_mid_i       (op_brand_mid),
    .brand_low_i       (op_brand_low),
    .record_handle_i   (op_handle),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .ok_o              (ok),
    .found_handle_o    (found_handle),
    .found_plate_o     (found_plate),
    .found_brand_high_o(found_brand_high),
    .found_brand_mid_o (found_brand_mid),
    .found_brand_low_o (found_brand_low),
    .stored_count_o    (stored_count)
  );

  keyed_record_table_checker #(
    .DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .kind_i            (op_kind),
    .plate_i           (op_plate),
    .brand_high_i      (op_brand_high),
    .brand_mid_i       (op_brand_mid),
    .brand_low_i       (op_brand_low),
    .record_handle_i   (op_handle),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .ok_i              (ok),
    .found_handle_i    (found_handle),
    .found_plate_i     (found_plate),
    .found_brand_high_i(found_brand_high),
    .found_brand_mid_i (found_brand_mid),
    .found_brand_low_i (found_brand_low),
    .stored_count_i    (stored_count),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("keyed_record_table test failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic entry_t random_key();
    entry_t         k;
    logic [159:0]   brand;
    int             len;
    k.handle = 16'($urandom);
    case ($urandom_range(9))
      0:       k.plate = '0;
      1:       k.plate = '1;
      default: k.plate = $urandom;
    endcase
    if ($urandom_range(1)) begin
      brand = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      // printable text, zero padded after the terminator
      brand = '0;
      len   = $urandom_range(20);
      for (int i = 0; i < len; i++) brand[159 - 8 * i -: 8] = 8'($urandom_range(32, 126));
    end
    k.brand_high = brand[159:96];
    k.brand_mid  = brand[95:32];
    k.brand_low  = brand[31:0];
    return k;
  endfunction

  task automatic send_op(input logic [2:0] kind, input entry_t e);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    op_kind       <= kind;
    op_plate      <= e.plate;
    op_brand_high <= e.brand_high;
    op_brand_mid  <= e.brand_mid;
    op_brand_low  <= e.brand_low;
    op_handle     <= e.handle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [5:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 63; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 63; end
      default:       begin send_idle_pct = 35; stall_pct = 35; end
    endcase
  endtask

  task automatic run_phase(input logic [5:0] cap, input idle_mode_e mode, input int n_items,
                           input bit long_hold, input bit drain_pause);
    int         r;
    entry_t     e;
    logic [2:0] kind;
    logic [191:0] flat;
    wait_drained();
    write_capacity(cap);
    set_idle(mode);
    // swap in some fresh keys, keep the rest so old entries can still be hit
    repeat (3) key_pool[$urandom_range(7)] = random_key();
    for (int i = 0; i < n_items; i++) begin
      if (long_hold && i == n_items / 2) hold_requests++;
      if (drain_pause && i == n_items / 2) begin
        wait_drained();
      end
      r = $urandom_range(99);
      if (r < 3) begin
        // full walk that runs the cursor into saturation
        send_op(KIND_FIRST, random_key());
        repeat (36) send_op(KIND_NEXT, random_key());
        i += 36;
      end else begin
        r = $urandom_range(99);
        if (r < 35)      kind = KIND_INSERT;
        else if (r < 55) kind = KIND_QUERY;
        else if (r < 72) kind = KIND_REMOVE;
        else if (r < 79) kind = KIND_FIRST;
        else if (r < 94) kind = KIND_NEXT;
        else             kind = 3'($urandom_range(KIND_UNKNOWN_FIRST, KIND_UNKNOWN_LAST));
        e = random_key();
        r = $urandom_range(99);
        if (kind == KIND_INSERT && r < 80) begin
          e        = key_pool[$urandom_range(7)];
          e.handle = 16'($urandom);
        end else if ((kind == KIND_QUERY || kind == KIND_REMOVE) && r < 87) begin
          e        = key_pool[$urandom_range(7)];
          e.handle = 16'($urandom);
          if (r >= 75) begin
            // near miss: one key bit flipped
            flat = {e.plate, e.brand_high, e.brand_mid, e.brand_low};
            r = $urandom_range(191);
            flat[r] = ~flat[r];
            {e.plate, e.brand_high, e.brand_mid, e.brand_low} = flat;
          end
        end
        send_op(kind, e);
      end
    end
  endtask

  initial begin
    entry_t key_ones;
    entry_t key_zero;
    entry_t key_text;
    entry_t key_tail;
    entry_t key_dup;

    key_ones            = '1;
    key_zero            = '0;
    key_text            = '0;
    key_text.handle     = 16'h1234;
    key_text.plate      = 32'h0000_0100;
    key_text.brand_high = {"abc", 40'h0};
    key_tail            = key_text;
    key_tail.handle     = 16'h4321;
    key_tail.brand_low  = 32'h0000_005A;  // byte after the terminator differs
    key_dup             = key_ones;
    key_dup.handle      = 16'h00FF;
    foreach (key_pool[i]) key_pool[i] = random_key();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table: nothing found, cursor untouched
    send_op(KIND_NEXT, key_ones);
    send_op(KIND_QUERY, key_ones);
    send_op(KIND_REMOVE, key_ones);
    send_op(KIND_FIRST, key_ones);
    send_op(KIND_INSERT, key_ones);
    send_op(KIND_INSERT, key_zero);
    send_op(KIND_INSERT, key_text);
    send_op(KIND_INSERT, key_tail);
    // next before any first returns entry 0
    send_op(KIND_NEXT, key_zero);
    send_op(KIND_QUERY, key_tail);
    send_op(KIND_QUERY, key_text);
    repeat (5) send_op(KIND_NEXT, key_zero);
    send_op(KIND_FIRST, key_zero);
    send_op(KIND_REMOVE, key_zero);
    send_op(KIND_NEXT, key_ones);
    send_op(KIND_INSERT, key_dup);
    send_op(KIND_QUERY, key_dup);
    for (int k = KIND_UNKNOWN_FIRST; k <= KIND_UNKNOWN_LAST; k++) send_op(3'(k), key_ones);
    send_op(KIND_REMOVE, key_ones);
    send_op(KIND_QUERY, key_zero);

    run_phase(6'd32, IDLE_NONE,     180, 1'b0, 1'b0);
    run_phase(6'd4,  IDLE_SENDER,   180, 1'b0, 1'b0);
    run_phase(6'd0,  IDLE_RECEIVER, 120, 1'b0, 1'b0);
    run_phase(6'd1,  IDLE_BOTH,     150, 1'b0, 1'b0);
    run_phase(6'd63, IDLE_NONE,     200, 1'b1, 1'b0);
    run_phase(6'd17, IDLE_SENDER,   180, 1'b0, 1'b1);
    run_phase(6'd32, IDLE_RECEIVER, 200, 1'b0, 1'b0);
    run_phase(6'd9,  IDLE_BOTH,     190, 1'b0, 1'b0);

    wait_drained();
    if (fail_count == 0) begin
      $display("keyed_record_table test passed");
    end else begin
      $display("keyed_record_table test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/krt_pkg.sv
sv/krt_cell.sv
sv/keyed_record_table.sv
tb/keyed_record_table_checker.sv
tb/keyed_record_table_tb.sv
